/* rtl/grid_extreme_path_sum_top_assert.svh */
// Assertion macros shared by the grid path-sum checkers.
`ifndef GRID_EXTREME_PATH_SUM_TOP_ASSERT_SVH
`define GRID_EXTREME_PATH_SUM_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define GEP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// Next-cycle implication, clocked on clk, off during reset.
`define GEP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`endif

/* rtl/gep_pkg.sv */
// Shared constants, types and helper functions for the grid path-sum block.
`timescale 1ns / 1ps

package gep_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int VAL_W  = 16;
  localparam int OUT_W  = 27;
  localparam int SIZE_W = 11;

  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  // wide enough that a path of MAX_ROWS + MAX_COLS - 1 cells never wraps
  localparam int SUM_W     = VAL_W + $clog2(MAX_ROWS + MAX_COLS) + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd2;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic             row0;
    logic             col0;
    logic             last;
    logic             want_max;
    logic [COL_W-1:0] addr;
  } cell_ctl_t;

  function automatic logic [COL_CNT_W-1:0] clamp_cols(input logic [SIZE_W-1:0] v);
    if (v == '0) return COL_CNT_W'(1);
    if (32'(v) > MAX_COLS) return COL_CNT_W'(MAX_COLS);
    return COL_CNT_W'(v);
  endfunction

  function automatic logic [ROW_CNT_W-1:0] clamp_rows(input logic [SIZE_W-1:0] v);
    if (v == '0) return ROW_CNT_W'(1);
    if (32'(v) > MAX_ROWS) return ROW_CNT_W'(MAX_ROWS);
    return ROW_CNT_W'(v);
  endfunction

  function automatic sum_t pick(input sum_t a, input sum_t b, input logic want_max);
    if (want_max) return (a > b) ? a : b;
    return (a < b) ? a : b;
  endfunction

endpackage

/* rtl/grid_extreme_path_sum_top.sv */
// Top level of the grid path-sum block: configuration, cell position, wiring.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------
//  in_     | input     | in_valid/in_stall | in_cell_value (16 b signed)
//  out_    | output    | out_valid/out_stall | out_path_sum (27 b signed)
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index (2 b), cfg_data (11 b)
//
// One cell per cycle while in_stall is low; the row buffer RAM is read and written at most once per cycle.
// A grid's result passes the cell pipeline's s1 register and is then written
// into the output queue, whose non-empty count drives out_valid.
// Reset clears position and control but not the row buffer; row 0 writes it first.
// in_stall rises when two results would sit in the output queue after this
// cycle, counting a push and a pop in flight; it follows out_stall combinationally.
`timescale 1ns / 1ps

module grid_extreme_path_sum_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [gep_pkg::VAL_W-1:0]     in_cell_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gep_pkg::OUT_W-1:0]     out_path_sum,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gep_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gep_pkg::SIZE_W-1:0]           cfg_data
);

  logic                          mode_max_r;
  logic [gep_pkg::SIZE_W-1:0]    num_rows_r;
  logic [gep_pkg::SIZE_W-1:0]    num_cols_r;
  logic [gep_pkg::ROW_W-1:0]     row_pos_r;
  logic [gep_pkg::COL_W-1:0]     col_pos_r;
  logic [gep_pkg::ROW_W-1:0]     row_pos_nxt;
  logic [gep_pkg::COL_W-1:0]     col_pos_nxt;

  logic [gep_pkg::COL_CNT_W-1:0] cols;
  logic [gep_pkg::ROW_CNT_W-1:0] rows;
  logic [gep_pkg::COL_W-1:0]     col_eff;
  logic                          col_last;
  logic                          row_last;
  logic                          in_acc;
  logic                          cfg_acc;
  logic                          room_ok;
  logic                          res_valid;
  logic signed [gep_pkg::OUT_W-1:0] res_sum;
  gep_pkg::cell_ctl_t            cell_ctl;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_stall  = !room_ok;
  assign in_acc    = in_valid && !in_stall;

  assign cols     = gep_pkg::clamp_cols(num_cols_r);
  assign rows     = gep_pkg::clamp_rows(num_rows_r);
  assign col_eff  = (gep_pkg::COL_CNT_W'(col_pos_r) >= cols) ? '0 : col_pos_r;
  assign col_last = (gep_pkg::COL_CNT_W'(col_eff) + gep_pkg::COL_CNT_W'(1)) >= cols;
  assign row_last = (gep_pkg::ROW_CNT_W'(row_pos_r) + gep_pkg::ROW_CNT_W'(1)) >= rows;

  assign cell_ctl.row0     = (row_pos_r == '0);
  assign cell_ctl.col0     = (col_eff == '0);
  assign cell_ctl.last     = col_last && row_last;
  assign cell_ctl.want_max = mode_max_r;
  assign cell_ctl.addr     = col_eff;

  always_comb begin
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    if (cfg_acc && (cfg_index == gep_pkg::CFG_NUM_ROWS ||
                    cfg_index == gep_pkg::CFG_NUM_COLS)) begin
      // restart the grid on any size change
      row_pos_nxt = '0;
      col_pos_nxt = '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_pos_nxt = '0;
        row_pos_nxt = row_last ? '0 : row_pos_r + gep_pkg::ROW_W'(1);
      end else begin
        col_pos_nxt = col_eff + gep_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_max_r <= 1'b0;
      num_rows_r <= gep_pkg::SIZE_W'(1);
      num_cols_r <= gep_pkg::SIZE_W'(1);
      row_pos_r  <= '0;
      col_pos_r  <= '0;
    end else begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
      if (cfg_acc) begin
        case (cfg_index)
          gep_pkg::CFG_MODE_MAX: mode_max_r <= cfg_data[0];
          gep_pkg::CFG_NUM_ROWS: num_rows_r <= cfg_data;
          gep_pkg::CFG_NUM_COLS: num_cols_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  gep_cell_pipe u_cell_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_acc   (in_acc),
    .cell_value (in_cell_value),
    .cell_ctl   (cell_ctl),
    .res_valid  (res_valid),
    .res_sum    (res_sum)
  );

  gep_out_fifo u_out_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (res_valid),
    .push_data    (res_sum),
    .room_ok      (room_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_path_sum (out_path_sum)
  );

endmodule

/* rtl/gep_row_ram.sv */
// Simple dual-port RAM with registered read data, holds one row of path sums.
`timescale 1ns / 1ps

module gep_row_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 28
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/gep_cell_pipe.sv */
// Read-modify-write pipeline: fetch the up sum, pick the extreme, write back.
`timescale 1ns / 1ps

module gep_cell_pipe (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cell_acc,
  input  logic signed [gep_pkg::VAL_W-1:0]  cell_value,
  input  gep_pkg::cell_ctl_t                cell_ctl,
  output logic                              res_valid,
  output logic signed [gep_pkg::OUT_W-1:0]  res_sum
);

  logic                              s1_valid_r;
  gep_pkg::cell_ctl_t                s1_ctl_r;
  logic signed [gep_pkg::VAL_W-1:0]  s1_value_r;
  logic                              fwd_r;
  gep_pkg::sum_t                     fwd_data_r;
  gep_pkg::sum_t                     left_r;
  gep_pkg::sum_t                     diag_r;

  logic [gep_pkg::SUM_W-1:0]         rd_data;
  gep_pkg::sum_t                     up;
  gep_pkg::sum_t                     v_ext;
  gep_pkg::sum_t                     sum;

  gep_row_ram #(
    .ADDR_W (gep_pkg::COL_W),
    .DATA_W (gep_pkg::SUM_W)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_ctl_r.addr),
    .wr_data (sum),
    .rd_en   (cell_acc),
    .rd_addr (cell_ctl.addr),
    .rd_data (rd_data)
  );

  // the RAM returns old data when the read meets a write to the same column
  assign up    = fwd_r ? fwd_data_r : gep_pkg::sum_t'(rd_data);
  assign v_ext = gep_pkg::SUM_W'(s1_value_r);

  always_comb begin
    if (s1_ctl_r.row0 && s1_ctl_r.col0) begin
      sum = v_ext;
    end else if (s1_ctl_r.row0) begin
      sum = left_r + v_ext;
    end else if (s1_ctl_r.col0) begin
      sum = up + v_ext;
    end else begin
      sum = v_ext + gep_pkg::pick(gep_pkg::pick(up, left_r, s1_ctl_r.want_max),
                                  diag_r, s1_ctl_r.want_max);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cell_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_acc) begin
      s1_ctl_r   <= cell_ctl;
      s1_value_r <= cell_value;
      fwd_r      <= s1_valid_r && (s1_ctl_r.addr == cell_ctl.addr);
      fwd_data_r <= sum;
    end
    if (s1_valid_r) begin
      left_r <= sum;
      diag_r <= up;
    end
  end

  assign res_valid = s1_valid_r && s1_ctl_r.last;
  assign res_sum   = gep_pkg::OUT_W'(sum);

endmodule

/* rtl/gep_out_fifo.sv */
// Two-entry result queue; tells the input side whether a new cell still fits.
`timescale 1ns / 1ps

module gep_out_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  logic signed [gep_pkg::OUT_W-1:0]  push_data,
  output logic                              room_ok,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gep_pkg::OUT_W-1:0]  out_path_sum
);

  logic signed [gep_pkg::OUT_W-1:0] entry_r [2];
  logic [1:0] cnt_r;
  logic       rd_ptr_r;
  logic       wr_ptr_r;
  logic       pop;
  logic [2:0] level;

  assign out_valid    = (cnt_r != 2'd0);
  assign out_path_sum = entry_r[rd_ptr_r];
  assign pop          = out_valid && !out_stall;

  // a pending result in flight still needs a slot after this cycle
  assign level   = 3'(cnt_r) - 3'(pop) + 3'(push);
  assign room_ok = (level < 3'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
    end else begin
      cnt_r <= 2'(3'(cnt_r) + 3'(push) - 3'(pop));
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/gep_checker.sv */
// Port-level checker for the grid path-sum block, bound to the top level.
`timescale 1ns / 1ps
`include "grid_extreme_path_sum_top_assert.svh"

module gep_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [gep_pkg::OUT_W-1:0]  out_path_sum
);

  // hold a stalled result and its value
  `GEP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `GEP_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_path_sum))
  // input backpressure comes only from a result backlog
  `GEP_ASSERT_IMP(a_stall_backlog, in_stall, out_valid)
  // a fresh result follows a cell transaction through the s1 register and the queue
  `GEP_ASSERT_IMP(a_res_latency, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind grid_extreme_path_sum_top gep_checker u_gep_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_path_sum (out_path_sum)
);

/* dv/testbench.sv */
// Self-checking testbench for the grid path-sum block: scoreboard, stimulus and result sink.
`timescale 1ns / 1ps

module testbench;
  import gep_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_TOP = 16'sh7FFF;
  localparam logic signed [VAL_W-1:0] VAL_BOTTOM = 16'sh8000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_CELLS = 360;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int LONG_LINE = 160;

  // Tracks the path sums of the grid in flight and the bottom-right sums still owed.
  class path_sum_board;
    sum_t                    col_sums [MAX_COLS];
    sum_t                    left_acc;
    sum_t                    diag_acc;
    int unsigned             row_at;
    int unsigned             col_at;
    logic                    take_max;
    logic [SIZE_W-1:0]       rows_raw;
    logic [SIZE_W-1:0]       cols_raw;
    logic signed [OUT_W-1:0] sums_due [$];
    int                      fail_count;

    function new();
      foreach (col_sums[i]) col_sums[i] = '0;
      left_acc = '0;
      diag_acc = '0;
      row_at = 0;
      col_at = 0;
      take_max = 1'b0;
      rows_raw = SIZE_W'(1);
      cols_raw = SIZE_W'(1);
      fail_count = 0;
    endfunction

    function int unsigned size_in_use(logic [SIZE_W-1:0] raw, int unsigned cap);
      if (raw == '0) return 1;
      if (raw > cap) return cap;
      return raw;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      case (idx)
        CFG_MODE_MAX: take_max = data[0];
        CFG_NUM_ROWS: begin
          rows_raw = data;
          row_at = 0;
          col_at = 0;
        end
        CFG_NUM_COLS: begin
          cols_raw = data;
          row_at = 0;
          col_at = 0;
        end
        default: ;
      endcase
    endfunction

    function void take_cell(logic signed [VAL_W-1:0] v);
      int unsigned rows;
      int unsigned cols;
      int unsigned c;
      sum_t        up;
      sum_t        best;
      sum_t        s;
      rows = size_in_use(rows_raw, MAX_ROWS);
      cols = size_in_use(cols_raw, MAX_COLS);
      c = (col_at >= cols) ? 0 : col_at;
      up = col_sums[c];
      best = up;
      if (take_max ? (left_acc > best) : (left_acc < best)) best = left_acc;
      if (take_max ? (diag_acc > best) : (diag_acc < best)) best = diag_acc;
      if (row_at == 0 && c == 0) s = sum_t'(v);
      else if (row_at == 0) s = left_acc + v;
      else if (c == 0) s = up + v;
      else s = best + v;
      diag_acc = up;
      col_sums[c] = s;
      left_acc = s;
      c++;
      if (c >= cols) begin
        c = 0;
        row_at++;
        if (row_at >= rows) begin
          row_at = 0;
          sums_due.push_back(s[OUT_W-1:0]);
        end
      end
      col_at = c;
    endfunction

    function void check_sum(logic signed [OUT_W-1:0] got);
      logic signed [OUT_W-1:0] want;
      if (sums_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("%0t: unexpected path sum %0d", $time, got);
        return;
      end
      want = sums_due.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: path sum mismatch: expected %0d, got %0d", $time, want, got);
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [VAL_W-1:0] in_cell_value;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] out_path_sum;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [SIZE_W-1:0]       cfg_data;

  path_sum_board board;
  int            burst_left;
  bit            long_hold_req;
  bit            long_hold_done;

  grid_extreme_path_sum_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_path_sum  (out_path_sum),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic signed [VAL_W-1:0] random_cell();
    case ($urandom_range(0, 7))
      0: return VAL_TOP;
      1: return VAL_BOTTOM;
      2: return VAL_W'($urandom_range(0, 15) - 8);
      default: return VAL_W'($urandom());
    endcase
  endfunction

  // Offer one cell, opening a new burst after a random gap when the last one ran out.
  task automatic send_cell(input logic signed [VAL_W-1:0] v);
    int gap;
    cfg_valid <= 1'b0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cell_value <= v;
    do @(posedge clk); while (in_stall);
    board.take_cell(v);
  endtask

  // Leave cfg_valid up; the next cell or settle drops it in the same step, a further write keeps it up.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
  endtask

  // Drain owed results, then let a partial grid's last cell clear the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    burst_left = 0;
    while (board.sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int hold_left;
    int mode_left;
    int stall_pct;
    hold_left = 0;
    mode_left = 0;
    stall_pct = 0;
    long_hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_sum(out_path_sum);
      if (long_hold_req && !long_hold_done) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 80);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        mode_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin : stimulus
    int rows_pick;
    int cols_pick;
    int area;
    int cells;
    int random_cells;
    board = new();
    burst_left = 0;
    long_hold_req = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cell_value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: minimum mode, single-cell grid
    send_cell(VAL_TOP);
    send_cell(VAL_BOTTOM);
    send_cell('0);

    settle();
    write_reg(CFG_MODE_MAX, 11'd1);
    write_reg(CFG_NUM_ROWS, 11'd2);
    write_reg(CFG_NUM_COLS, 11'd3);
    send_cell(VAL_BOTTOM);
    send_cell(VAL_TOP);
    send_cell(-16'sd1);
    send_cell(16'sd1);
    send_cell(VAL_BOTTOM);
    send_cell(VAL_TOP);

    // flip the mode halfway through a grid
    settle();
    write_reg(CFG_MODE_MAX, 11'd0);
    send_cell(16'sd5);
    send_cell(-16'sd7);
    send_cell(16'sd3);
    settle();
    write_reg(CFG_MODE_MAX, 11'd1);
    send_cell(16'sd100);
    send_cell(-16'sd200);
    send_cell(16'sd300);

    // zero sizes act as one; the size write also abandons the partial grid
    send_cell(16'sd7);
    send_cell(16'sd8);
    settle();
    write_reg(CFG_NUM_ROWS, 11'd0);
    write_reg(CFG_NUM_COLS, 11'd0);
    send_cell(-16'sd1);
    send_cell(VAL_TOP);

    // unknown register index is ignored
    settle();
    write_reg(CFG_SPARE, 11'h7FF);
    send_cell(16'sd42);

    // hold the result side off while single-cell grids keep coming
    settle();
    write_reg(CFG_NUM_ROWS, 11'd1);
    write_reg(CFG_NUM_COLS, 11'd1);
    long_hold_req = 1'b1;
    repeat (40) send_cell(random_cell());

    random_cells = 0;
    while (random_cells < RANDOM_CELLS) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        rows_pick = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        cols_pick = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        if ($urandom_range(0, 1) != 0) begin
          write_reg(CFG_NUM_ROWS, SIZE_W'(rows_pick));
          write_reg(CFG_NUM_COLS, SIZE_W'(cols_pick));
        end else begin
          write_reg(CFG_NUM_COLS, SIZE_W'(cols_pick));
          write_reg(CFG_NUM_ROWS, SIZE_W'(rows_pick));
        end
      end
      write_reg(CFG_MODE_MAX, SIZE_W'($urandom_range(0, 2047)));
      if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, SIZE_W'($urandom_range(0, 2047)));
      area = board.size_in_use(board.rows_raw, MAX_ROWS)
           * board.size_in_use(board.cols_raw, MAX_COLS);
      cells = $urandom_range(1, 3) * area;
      if ($urandom_range(0, 2) == 0) cells += $urandom_range(0, area - 1);
      repeat (cells) send_cell(random_cell());
      random_cells += cells;
    end

    // long single row and long single column at full swing
    settle();
    write_reg(CFG_MODE_MAX, 11'd1);
    write_reg(CFG_NUM_ROWS, 11'd1);
    write_reg(CFG_NUM_COLS, SIZE_W'(LONG_LINE));
    repeat (LONG_LINE) send_cell(VAL_TOP);
    settle();
    write_reg(CFG_MODE_MAX, 11'd0);
    write_reg(CFG_NUM_COLS, 11'd1);
    write_reg(CFG_NUM_ROWS, SIZE_W'(LONG_LINE));
    repeat (LONG_LINE) send_cell(VAL_BOTTOM);

    settle();
    if (board.fail_count == 0 && board.sums_due.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
